### rtl/core/pidaw_pkg.sv
// Shared types, register indexes, step codes and saturation helpers for the PID controller.
package pidaw_pkg;

    // Input item of one control sample
    typedef struct packed {
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
        logic               rate_valid;
        logic signed [31:0] measured_rate;
        logic signed [31:0] out_min;
        logic signed [31:0] out_max;
    } in_t;

    // Result item of one control sample
    typedef struct packed {
        logic signed [31:0] drive;
        logic               clamped;
    } out_t;

    // Configuration register file contents
    typedef struct packed {
        logic [23:0] prop_gain;
        logic [23:0] int_gain;
        logic [23:0] deriv_gain;
        logic [16:0] filter_coeff;
        logic [23:0] sample_period;
        logic [23:0] inv_sample_period;
    } cfg_t;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 24;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INT_GAIN      = 3'd1,
        CFG_DERIV_GAIN    = 3'd2,
        CFG_FILTER_COEFF  = 3'd3,
        CFG_SAMPLE_PERIOD = 3'd4,
        CFG_INV_PERIOD    = 3'd5
    } cfg_idx_t;

    localparam logic [23:0] RstPropGain    = 24'd0;
    localparam logic [23:0] RstIntGain     = 24'd0;
    localparam logic [23:0] RstDerivGain   = 24'd0;
    localparam logic [16:0] RstFilterCoeff = 17'd65536;
    localparam logic [23:0] RstSamplePer   = 24'd167772;
    localparam logic [23:0] RstInvPer      = 24'd25600;

    // Datapath step codes issued by the sequencer
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_INT,
        OP_LAG,
        OP_PROP,
        OP_DERIV,
        OP_IHI,
        OP_ILO,
        OP_SUM,
        OP_COMMIT
    } dp_op_t;

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < 64'shFFFF_FFFF_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Saturate a 64-bit signed value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sh0000_7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < 64'shFFFF_8000_0000_0000)
            r = 48'sh8000_0000_0000;
        else
            r = v[47:0];
        return r;
    endfunction

endpackage

### rtl/core/pid_antiwindup_controller.sv
// Top level of the PID controller with filtered derivative and conditional integration.
// One control sample per input transfer: the block takes a sample, then is busy while a
// single shared 33x25 multiplier works through seven products (derivative, integral
// increment, lag filter, proportional, derivative gain, and the integral gain in two
// halves), and places the result in an output register; it takes no new sample until
// that result is committed and it is idle again. A result waiting in the output register
// does not stop the next sample from being taken; only its final commit waits for the
// register to empty. Configuration registers are written through cfg_wr_en/cfg_index/
// cfg_wdata; the user must write them only while the block is idle, which the block
// itself does not enforce; indexes 6 and 7 are ignored.
module pid_antiwindup_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [pidaw_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [pidaw_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pidaw_pkg::in_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pidaw_pkg::out_t                out_data
);

    pidaw_pkg::cfg_t   cfg;
    pidaw_pkg::dp_op_t op;

    pidaw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidaw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .op        (op)
    );

    pidaw_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .cfg      (cfg),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

### rtl/core/pidaw_cfg.sv
// Configuration register file for the PID controller.
module pidaw_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [pidaw_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [pidaw_pkg::CfgDataW-1:0] cfg_wdata,
    output pidaw_pkg::cfg_t                cfg
);

    pidaw_pkg::cfg_t cfg_reg;
    pidaw_pkg::cfg_t cfg_next;

    // Decode the write index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (pidaw_pkg::cfg_idx_t'(cfg_index))
                pidaw_pkg::CFG_PROP_GAIN:     cfg_next.prop_gain         = cfg_wdata;
                pidaw_pkg::CFG_INT_GAIN:      cfg_next.int_gain          = cfg_wdata;
                pidaw_pkg::CFG_DERIV_GAIN:    cfg_next.deriv_gain        = cfg_wdata;
                pidaw_pkg::CFG_FILTER_COEFF:  cfg_next.filter_coeff      = cfg_wdata[16:0];
                pidaw_pkg::CFG_SAMPLE_PERIOD: cfg_next.sample_period     = cfg_wdata;
                pidaw_pkg::CFG_INV_PERIOD:    cfg_next.inv_sample_period = cfg_wdata;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain         <= pidaw_pkg::RstPropGain;
            cfg_reg.int_gain          <= pidaw_pkg::RstIntGain;
            cfg_reg.deriv_gain        <= pidaw_pkg::RstDerivGain;
            cfg_reg.filter_coeff      <= pidaw_pkg::RstFilterCoeff;
            cfg_reg.sample_period     <= pidaw_pkg::RstSamplePer;
            cfg_reg.inv_sample_period <= pidaw_pkg::RstInvPer;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/pidaw_ctrl.sv
// Sequencer for the PID controller: steps the shared multiplier and owns the handshakes.
module pidaw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pidaw_pkg::dp_op_t op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_INT,
        ST_LAG,
        ST_PROP,
        ST_DERIV,
        ST_IHI,
        ST_ILO,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Advance one datapath step per cycle; idle and done wait on the handshakes
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op             = pidaw_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = pidaw_pkg::OP_LOAD;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                op         = pidaw_pkg::OP_DIFF;
                state_next = ST_INT;
            end
            ST_INT:
            begin
                op         = pidaw_pkg::OP_INT;
                state_next = ST_LAG;
            end
            ST_LAG:
            begin
                op         = pidaw_pkg::OP_LAG;
                state_next = ST_PROP;
            end
            ST_PROP:
            begin
                op         = pidaw_pkg::OP_PROP;
                state_next = ST_DERIV;
            end
            ST_DERIV:
            begin
                op         = pidaw_pkg::OP_DERIV;
                state_next = ST_IHI;
            end
            ST_IHI:
            begin
                op         = pidaw_pkg::OP_IHI;
                state_next = ST_ILO;
            end
            ST_ILO:
            begin
                op         = pidaw_pkg::OP_ILO;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                op         = pidaw_pkg::OP_SUM;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Commit only once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    op             = pidaw_pkg::OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/core/pidaw_dp.sv
// Datapath of the PID controller: shared 33x25 multiplier, accumulators, clamp and state.
module pidaw_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  pidaw_pkg::dp_op_t op,
    input  pidaw_pkg::cfg_t   cfg,
    input  pidaw_pkg::in_t    in_data,
    output pidaw_pkg::out_t   out_data
);

    // Loop state
    logic signed [47:0] integral_acc_reg;
    logic signed [31:0] deriv_filtered_reg;
    logic signed [31:0] last_error_reg;

    // Per-sample working registers
    logic signed [31:0] err_reg;
    logic               rate_valid_reg;
    logic signed [31:0] rate_reg;
    logic signed [31:0] min_reg;
    logic signed [31:0] max_reg;
    logic signed [31:0] dterm_reg;
    logic signed [47:0] inew_reg;
    logic signed [31:0] dnew_reg;
    logic signed [49:0] sum_reg;
    logic signed [49:0] sum_next;
    logic signed [57:0] prod_reg;
    logic signed [57:0] prod_next;
    pidaw_pkg::out_t    out_reg;

    logic signed [32:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [41:0] prod_sh16;
    logic signed [49:0] prod_sh8;
    logic signed [31:0] err_load;
    logic signed [63:0] lag_sum;
    logic signed [63:0] int_sum;
    logic signed [49:0] hi_ext;
    logic signed [49:0] lo_ext;
    logic signed [31:0] drive;
    logic               over_hi;
    logic               under_lo;
    logic               keep_int;

    assign prod_sh16 = prod_reg[57:16];
    assign prod_sh8  = prod_reg[57:8];
    assign err_load  = pidaw_pkg::sat32(64'(in_data.setpoint) - 64'(in_data.measured));
    assign lag_sum   = 64'(deriv_filtered_reg) + 64'(prod_sh16);
    assign int_sum   = 64'(integral_acc_reg) + 64'(prod_sh16);

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            pidaw_pkg::OP_DIFF:
            begin
                mul_a = 33'(last_error_reg) - 33'(err_reg);
                mul_b = $signed({1'b0, cfg.inv_sample_period});
            end
            pidaw_pkg::OP_INT:
            begin
                mul_a = 33'(err_reg);
                mul_b = $signed({1'b0, cfg.sample_period});
            end
            pidaw_pkg::OP_LAG:
            begin
                mul_a = 33'(dterm_reg) - 33'(deriv_filtered_reg);
                mul_b = $signed({8'b0, cfg.filter_coeff});
            end
            pidaw_pkg::OP_PROP:
            begin
                mul_a = 33'(err_reg);
                mul_b = $signed({1'b0, cfg.prop_gain});
            end
            pidaw_pkg::OP_DERIV:
            begin
                mul_a = 33'(dnew_reg);
                mul_b = $signed({1'b0, cfg.deriv_gain});
            end
            pidaw_pkg::OP_IHI:
            begin
                // Upper 20 bits of the 48-bit integral in Q24.24, signed
                mul_a = 33'($signed(inew_reg[47:28]));
                mul_b = $signed({1'b0, cfg.int_gain});
            end
            pidaw_pkg::OP_ILO:
            begin
                // Bits 27:8 of the 48-bit integral in Q24.24, unsigned; bits 7:0 are dropped
                mul_a = $signed({13'b0, inew_reg[27:8]});
                mul_b = $signed({1'b0, cfg.int_gain});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Accumulate the output terms
    always_comb
    begin
        sum_next = sum_reg;
        case (op)
            pidaw_pkg::OP_DERIV: sum_next = 50'(prod_sh16);
            pidaw_pkg::OP_IHI:   sum_next = sum_reg - 50'(prod_sh16);
            pidaw_pkg::OP_ILO:   sum_next = sum_reg + (50'(prod_reg) <<< 4);
            pidaw_pkg::OP_SUM:   sum_next = sum_reg + 50'(prod_sh16);
            default:             sum_next = sum_reg;
        endcase
    end

    // Clamp against the limits, upper limit first
    always_comb
    begin
        hi_ext   = 50'(max_reg);
        lo_ext   = 50'(min_reg);
        over_hi  = (sum_reg > hi_ext);
        under_lo = !over_hi && (sum_reg < lo_ext);
        if (over_hi)
            drive = max_reg;
        else if (under_lo)
            drive = min_reg;
        else
            drive = sum_reg[31:0];
        keep_int = !(over_hi || under_lo)
                   || ((drive == max_reg) && (err_reg < 0))
                   || ((drive == min_reg) && (err_reg > 0));
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        case (op)
            pidaw_pkg::OP_LOAD:
            begin
                err_reg        <= err_load;
                rate_valid_reg <= in_data.rate_valid;
                rate_reg       <= in_data.measured_rate;
                min_reg        <= in_data.out_min;
                max_reg        <= in_data.out_max;
            end
            pidaw_pkg::OP_INT:
            begin
                dterm_reg <= rate_valid_reg ? rate_reg
                                            : pidaw_pkg::sat32(64'(prod_sh8));
            end
            pidaw_pkg::OP_LAG:
            begin
                inew_reg <= pidaw_pkg::sat48(int_sum);
            end
            pidaw_pkg::OP_PROP:
            begin
                dnew_reg <= pidaw_pkg::sat32(lag_sum);
            end
            pidaw_pkg::OP_COMMIT:
            begin
                out_reg.drive   <= drive;
                out_reg.clamped <= over_hi || under_lo;
            end
            default:
            begin
            end
        endcase
    end

    // Loop state, updated when the result is committed (the integral only when integration is kept)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_acc_reg   <= '0;
            deriv_filtered_reg <= '0;
            last_error_reg     <= '0;
        end
        else if (op == pidaw_pkg::OP_COMMIT)
        begin
            if (keep_int)
                integral_acc_reg <= inew_reg;
            deriv_filtered_reg <= dnew_reg;
            last_error_reg     <= err_reg;
        end
    end

    assign out_data = out_reg;

endmodule

### rtl/core/pidaw_checker.sv
// Port-level checker for the PID controller, bound to the top level.
module pidaw_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input pidaw_pkg::out_t out_data
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // A taken sample leaves the input side busy, so no second sample is taken straight after it
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken again too early");

    // No result appears in the cycle right after a sample is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared without computation time");

    // Out of reset the block is idle with no result pending
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_ready && !out_valid)
        else $error("block not idle after reset");

endmodule

bind pid_antiwindup_controller pidaw_checker u_pidaw_checker (.*);
